/* rtl/sliding_window_transport_endpoint_unit_assert.svh */
// Assertion macros used by the port checker file.
`ifndef SLIDING_WINDOW_TRANSPORT_ENDPOINT_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_TRANSPORT_ENDPOINT_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SWTE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same cycle check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define SWTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

/* rtl/swte_pkg.sv */
// ---------------------------------------------------------------------------
// swte_pkg
// Types and constants of the sliding window endpoint.
// ---------------------------------------------------------------------------
package swte_pkg;
   localparam int RECV_SLOTS_DEF = 32;
   localparam int SEND_SLOTS_DEF = 32;
   localparam logic [5:0]  WINDOW_RESET  = 6'd20;
   localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

   typedef enum logic [1:0] {
      ACT_RECV = 2'd0,
      ACT_SEND = 2'd1,
      ACT_TICK = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_DELIVER = 2'd0,
      KIND_ACK     = 2'd1,
      KIND_NEW     = 2'd2,
      KIND_RETX    = 2'd3
   } kind_type;

   typedef enum logic {
      CSR_WINDOW  = 1'b0,
      CSR_TIMEOUT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DRAIN,
      ST_ACK
   } state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] pkt_number;
      logic [31:0] ack_number;
      logic [15:0] payload_handle;
      logic [10:0] payload_length;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] seq_out;
      logic [31:0] ack_out;
      logic [15:0] handle_out;
      logic [10:0] length_out;
      logic        last;
   } rsp_type;

   // payload kept per slot
   typedef struct packed {
      logic [15:0] handle;
      logic [10:0] length;
   } slot_type;
endpackage

/* rtl/sliding_window_transport_endpoint_unit.sv */
// Sliding window endpoint. An accepted command (start high, busy low) runs in
// ST_EXEC; a received data packet then goes through ST_DRAIN, which walks the
// reorder ring one slot per cycle through its registered memory read,
// delivering each in-order payload until it finds the first empty slot, and
// then ST_ACK, which sends the ack. Each result appears on the rsp_ ports for one
// cycle with rsp_valid high; the receiver cannot stall, and last marks the
// final result of a command. busy stays high until a command's results are out.
// ---------------------------------------------------------------------------
// sliding_window_transport_endpoint_unit
// Send and receive window bookkeeping with reorder and retransmit stores.
// ---------------------------------------------------------------------------
module sliding_window_transport_endpoint_unit #(
   parameter int RECV_SLOTS = swte_pkg::RECV_SLOTS_DEF,
   parameter int SEND_SLOTS = swte_pkg::SEND_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  swte_pkg::req_type req_word,
   output logic              rsp_valid,
   output swte_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [31:0]       csr_data
);
   localparam int RB = $clog2(RECV_SLOTS);
   localparam int SB = $clog2(SEND_SLOTS);

   // configuration
   logic [5:0]  window_ff;
   logic [31:0] timeout_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= swte_pkg::WINDOW_RESET;
         timeout_ff <= swte_pkg::TIMEOUT_RESET;
      end else if (csr_valid) begin
         unique case (swte_pkg::csr_index_type'(csr_index))
            swte_pkg::CSR_WINDOW:  window_ff  <= csr_data[5:0];
            swte_pkg::CSR_TIMEOUT: timeout_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // control state
   swte_pkg::state_type state_ff, state_in;
   swte_pkg::req_type   req_ff;
   logic [31:0] recv_base_ff, recv_base_in;
   logic [31:0] send_base_ff, send_base_in;
   logic [31:0] next_seq_ff, next_seq_in;
   logic        timer_run_ff, timer_run_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [RECV_SLOTS-1:0] rvalid_ff, rvalid_in;

   // memories
   logic          r_we, s_we;
   logic [RB-1:0] r_waddr, r_raddr;
   logic [SB-1:0] s_waddr, s_raddr;
   swte_pkg::slot_type r_rdata, s_rdata, wdata;
   assign wdata = '{handle: req_ff.payload_handle, length: req_ff.payload_length};

   swte_ring #(.SLOTS(RECV_SLOTS)) u_recv (
      .clock(clock), .wr_en(r_we), .wr_addr(r_waddr), .wr_data(wdata),
      .rd_addr(r_raddr), .rd_data(r_rdata));
   swte_ring #(.SLOTS(SEND_SLOTS)) u_send (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(wdata),
      .rd_addr(s_raddr), .rd_data(s_rdata));

   // forwarded receive read data
   swte_pkg::slot_type rd_fwd;
   logic               fwd_ff;

   logic accept;
   assign busy   = (state_ff != swte_pkg::ST_IDLE);
   assign accept = start && !busy;

   // derived values for the held command
   logic [31:0] outstanding, ack_off, pkt_dist, sb_new, elapsed_inc, limit, win;
   logic        ack_ok, in_win, store_ok, retx;
   logic [RB-1:0] pslot;
   always_comb begin
      outstanding = next_seq_ff - send_base_ff;
      ack_off     = req_ff.ack_number - send_base_ff;
      ack_ok      = ack_off < outstanding;
      sb_new      = ack_ok ? req_ff.ack_number + 32'd1 : send_base_ff;
      pkt_dist    = req_ff.pkt_number - recv_base_ff;
      pslot       = req_ff.pkt_number[RB-1:0];
      store_ok    = (pkt_dist < 32'(RECV_SLOTS)) && !rvalid_ff[pslot];
      win         = (window_ff == 6'd0) ? 32'd1 :
                    ((32'(window_ff) > 32'(SEND_SLOTS)) ? 32'(SEND_SLOTS) :
                     32'(window_ff));
      in_win      = outstanding < win;
      limit       = (timeout_ff == 32'd0) ? 32'd1 : timeout_ff;
      elapsed_inc = (elapsed_ff != 32'hFFFF_FFFF) ? elapsed_ff + 32'd1 : elapsed_ff;
      retx        = timer_run_ff && (elapsed_inc >= limit);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         swte_pkg::ST_IDLE:  if (accept) state_in = swte_pkg::ST_EXEC;
         swte_pkg::ST_EXEC:
            state_in = (req_ff.action == swte_pkg::ACT_RECV &&
                        req_ff.pkt_number != 32'd0) ?
                       swte_pkg::ST_DRAIN : swte_pkg::ST_IDLE;
         swte_pkg::ST_DRAIN: if (!rvalid_ff[recv_base_ff[RB-1:0]])
                                state_in = swte_pkg::ST_ACK;
         swte_pkg::ST_ACK:   state_in = swte_pkg::ST_IDLE;
         default:            state_in = swte_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      recv_base_in = recv_base_ff;
      send_base_in = send_base_ff;
      next_seq_in  = next_seq_ff;
      timer_run_in = timer_run_ff;
      elapsed_in   = elapsed_ff;
      rvalid_in    = rvalid_ff;
      r_we = 1'b0; s_we = 1'b0;
      r_waddr = pslot;
      s_waddr = next_seq_ff[SB-1:0];
      r_raddr = recv_base_ff[RB-1:0];
      s_raddr = send_base_ff[SB-1:0];
      rsp_valid = 1'b0;
      rsp_word  = '0;
      unique case (state_ff)
         swte_pkg::ST_IDLE: ;
         swte_pkg::ST_EXEC: begin
            unique case (swte_pkg::action_type'(req_ff.action))
               swte_pkg::ACT_RECV: begin
                  send_base_in = sb_new;
                  if (ack_ok) begin
                     if (sb_new == next_seq_ff) timer_run_in = 1'b0;
                     else elapsed_in = 32'd0;
                  end
                  if (req_ff.pkt_number != 32'd0 && store_ok) begin
                     r_we = 1'b1;
                     rvalid_in[pslot] = 1'b1;
                  end
               end
               swte_pkg::ACT_SEND: if (in_win) begin
                  s_we = 1'b1;
                  rsp_valid = 1'b1;
                  rsp_word = '{kind: swte_pkg::KIND_NEW, seq_out: next_seq_ff,
                               ack_out: recv_base_ff - 32'd1,
                               handle_out: req_ff.payload_handle,
                               length_out: req_ff.payload_length, last: 1'b1};
                  next_seq_in = next_seq_ff + 32'd1;
                  if (!timer_run_ff) begin
                     timer_run_in = 1'b1;
                     elapsed_in   = 32'd0;
                  end
               end
               swte_pkg::ACT_TICK: if (timer_run_ff) begin
                  elapsed_in = retx ? 32'd0 : elapsed_inc;
                  if (retx && send_base_ff != next_seq_ff) begin
                     rsp_valid = 1'b1;
                     rsp_word = '{kind: swte_pkg::KIND_RETX, seq_out: send_base_ff,
                                  ack_out: recv_base_ff - 32'd1,
                                  handle_out: s_rdata.handle,
                                  length_out: s_rdata.length, last: 1'b1};
                  end
               end
               default: ;
            endcase
         end
         swte_pkg::ST_DRAIN: begin
            // the read issued last cycle is for recv_base; a slot just
            // written at that address is forwarded from the command
            if (rvalid_ff[recv_base_ff[RB-1:0]]) begin
               rsp_valid = 1'b1;
               rsp_word = '{kind: swte_pkg::KIND_DELIVER, seq_out: recv_base_ff,
                            ack_out: 32'd0, handle_out: rd_fwd.handle,
                            length_out: rd_fwd.length, last: 1'b0};
               rvalid_in[recv_base_ff[RB-1:0]] = 1'b0;
               recv_base_in = recv_base_ff + 32'd1;
               r_raddr = recv_base_in[RB-1:0];
            end
         end
         swte_pkg::ST_ACK: begin
            rsp_valid = 1'b1;
            rsp_word = '{kind: swte_pkg::KIND_ACK, seq_out: 32'd0,
                         ack_out: recv_base_ff - 32'd1, handle_out: 16'd0,
                         length_out: 11'd0, last: 1'b1};
         end
         default: ;
      endcase
   end

   // forwarding of a payload written in the execute cycle
   always_ff @(posedge clock) begin
      fwd_ff <= r_we && (r_waddr == r_raddr);
   end
   assign rd_fwd = fwd_ff ? wdata : r_rdata;

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swte_pkg::ST_IDLE;
         recv_base_ff <= 32'd1;
         send_base_ff <= 32'd1;
         next_seq_ff  <= 32'd1;
         timer_run_ff <= 1'b0;
         elapsed_ff   <= 32'd0;
         rvalid_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         recv_base_ff <= recv_base_in;
         send_base_ff <= send_base_in;
         next_seq_ff  <= next_seq_in;
         timer_run_ff <= timer_run_in;
         elapsed_ff   <= elapsed_in;
         rvalid_ff    <= rvalid_in;
      end
   end
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_word;
      end
   end
endmodule

/* rtl/swte_ring.sv */
// ---------------------------------------------------------------------------
// swte_ring
// Slot store: synchronous memory with one write port and one read port,
// with a registered read.
// ---------------------------------------------------------------------------
module swte_ring #(
   parameter int SLOTS = swte_pkg::RECV_SLOTS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(SLOTS)-1:0] wr_addr,
   input  swte_pkg::slot_type       wr_data,
   input  logic [$clog2(SLOTS)-1:0] rd_addr,
   output swte_pkg::slot_type       rd_data
);
   swte_pkg::slot_type mem [SLOTS];
   swte_pkg::slot_type rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/swte_checker.sv */
// ---------------------------------------------------------------------------
// swte_port_checker
// Port level checks of the endpoint, bound to the top level.
// ---------------------------------------------------------------------------
`include "sliding_window_transport_endpoint_unit_assert.svh"
module swte_port_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input swte_pkg::rsp_type rsp_word
);
   // an accepted command occupies the block in the next cycle
   `SWTE_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // results only while a command is in flight
   `SWTE_ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid, busy)
   // a final result frees the block
   `SWTE_ASSERT_NEXT(a_last_frees, clock, reset, rsp_valid && rsp_word.last, !busy)
   // a delivery is never the final result
   `SWTE_ASSERT_IMP(a_deliver_not_last, clock, reset,
      rsp_valid && rsp_word.kind == swte_pkg::KIND_DELIVER, !rsp_word.last)
endmodule

bind sliding_window_transport_endpoint_unit swte_port_checker u_swte_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_word(rsp_word));

/* test/swte_checker.sv */
// ---------------------------------------------------------------------------
// swte_checker
// Watches the command, result and register channels of the window endpoint.
// It keeps its own copy of the send and receive windows, works out the
// results each accepted command should give and compares every result word
// against the oldest one still expected.
// ---------------------------------------------------------------------------
module swte_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  swte_pkg::req_type req_word,
   input  logic              rsp_valid,
   input  swte_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic              csr_index,
   input  logic [31:0]       csr_data,
   output int                fail_count,
   output int                pending_count,
   output int                result_count,
   output logic [31:0]       cur_recv_base,
   output logic [31:0]       cur_send_base,
   output logic [31:0]       cur_next_seq
);
   localparam int RSLOTS = swte_pkg::RECV_SLOTS_DEF;
   localparam int SSLOTS = swte_pkg::SEND_SLOTS_DEF;

   // window state as the block should hold it
   logic [5:0]  win_reg;
   logic [31:0] tmo_reg;
   logic [31:0] recv_base, send_base, next_seq, tick_count;
   logic        timer_on;
   logic                  rx_full   [RSLOTS];
   swte_pkg::slot_type    rx_store  [RSLOTS];
   swte_pkg::slot_type    tx_store  [SSLOTS];
   swte_pkg::rsp_type     expected_words[$];
   int          errs, seen;

   function automatic swte_pkg::rsp_type make_word(swte_pkg::kind_type k,
                                                   logic [31:0] seq, logic [31:0] ack,
                                                   logic [15:0] h, logic [10:0] len);
      swte_pkg::rsp_type w;
      w.kind = k;
      w.seq_out = seq;
      w.ack_out = ack;
      w.handle_out = h;
      w.length_out = len;
      w.last = 1'b0;
      return w;
   endfunction

   // work out the result words of one accepted command
   task automatic predict_command(input swte_pkg::req_type r);
      swte_pkg::rsp_type words[$];
      logic [31:0] outstanding, pkt_dist, win, lim;
      int          slot;
      case (swte_pkg::action_type'(r.action))
         swte_pkg::ACT_RECV: begin
            outstanding = next_seq - send_base;
            if ((r.ack_number - send_base) < outstanding) begin
               send_base = r.ack_number + 1;
               if (send_base == next_seq) timer_on = 1'b0;
               else tick_count = '0;
            end
            if (r.pkt_number != 0) begin
               pkt_dist = r.pkt_number - recv_base;
               if (pkt_dist < RSLOTS) begin
                  slot = r.pkt_number % RSLOTS;
                  if (!rx_full[slot]) begin
                     rx_full[slot] = 1'b1;
                     rx_store[slot] = '{r.payload_handle, r.payload_length};
                  end
               end
               // in-order run at the base of the ring
               for (int g = 0; g < RSLOTS; g++) begin
                  slot = recv_base % RSLOTS;
                  if (!rx_full[slot]) break;
                  words.push_back(make_word(swte_pkg::KIND_DELIVER, recv_base, '0,
                                            rx_store[slot].handle, rx_store[slot].length));
                  rx_full[slot] = 1'b0;
                  recv_base++;
               end
               words.push_back(make_word(swte_pkg::KIND_ACK, '0, recv_base - 1, '0, '0));
            end
         end
         swte_pkg::ACT_SEND: begin
            win = (win_reg == 0) ? 1 : (win_reg > SSLOTS) ? SSLOTS : win_reg;
            if ((next_seq - send_base) < win) begin
               tx_store[next_seq % SSLOTS] = '{r.payload_handle, r.payload_length};
               words.push_back(make_word(swte_pkg::KIND_NEW, next_seq, recv_base - 1,
                                         r.payload_handle, r.payload_length));
               next_seq++;
               if (!timer_on) begin
                  timer_on = 1'b1;
                  tick_count = '0;
               end
            end
         end
         swte_pkg::ACT_TICK: begin
            if (timer_on) begin
               lim = (tmo_reg == 0) ? 1 : tmo_reg;
               if (tick_count != 32'hFFFF_FFFF) tick_count++;
               if (tick_count >= lim) begin
                  if (send_base != next_seq) begin
                     slot = send_base % SSLOTS;
                     words.push_back(make_word(swte_pkg::KIND_RETX, send_base,
                                               recv_base - 1, tx_store[slot].handle,
                                               tx_store[slot].length));
                  end
                  tick_count = '0;
               end
            end
         end
         default: ;
      endcase
      if (words.size() > 0) words[words.size() - 1].last = 1'b1;
      foreach (words[i]) expected_words.push_back(words[i]);
   endtask

   always @(posedge clock) begin
      swte_pkg::rsp_type want;
      if (reset) begin
         win_reg = swte_pkg::WINDOW_RESET;
         tmo_reg = swte_pkg::TIMEOUT_RESET;
         recv_base = 1;
         send_base = 1;
         next_seq = 1;
         timer_on = 1'b0;
         tick_count = '0;
         foreach (rx_full[i]) rx_full[i] = 1'b0;
         expected_words.delete();
         errs = 0;
         seen = 0;
      end else begin
         // result side
         if (rsp_valid) begin
            seen++;
            if (expected_words.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("unexpected result word: expected none, got %p", rsp_word);
            end else begin
               want = expected_words.pop_front();
               if (rsp_word.kind !== want.kind || rsp_word.seq_out !== want.seq_out ||
                   rsp_word.ack_out !== want.ack_out ||
                   rsp_word.handle_out !== want.handle_out ||
                   rsp_word.length_out !== want.length_out || rsp_word.last !== want.last)
               begin
                  errs++;
                  if (errs <= 10)
                     $display("result mismatch: expected %p, got %p", want, rsp_word);
               end
            end
         end
         // register writes
         if (csr_valid && csr_ready) begin
            if (csr_index == swte_pkg::CSR_WINDOW) win_reg = csr_data[5:0];
            else tmo_reg = csr_data;
         end
         // accepted command
         if (start && !busy) predict_command(req_word);
      end
      fail_count    <= errs;
      pending_count <= expected_words.size();
      result_count  <= seen;
      cur_recv_base <= recv_base;
      cur_send_base <= send_base;
      cur_next_seq  <= next_seq;
   end
endmodule

/* test/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sliding window endpoint.
// A directed sequence covers the corner cases, then random traffic runs under
// several window and timeout settings; the checker does all comparison.
// ---------------------------------------------------------------------------
module tb_top;
   logic              clock, reset, start, busy, rsp_valid;
   logic              csr_valid, csr_ready, csr_index;
   logic [31:0]       csr_data;
   swte_pkg::req_type req_word;
   swte_pkg::rsp_type rsp_word;
   int          fail_count, pending_count, result_count, word_count, cycles;
   logic [31:0] cur_recv_base, cur_send_base, cur_next_seq;

   sliding_window_transport_endpoint_unit dut (
      .clock, .reset, .start, .busy, .req_word, .rsp_valid, .rsp_word,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   swte_checker chk (
      .clock, .reset, .start, .busy, .req_word, .rsp_valid, .rsp_word,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .pending_count, .result_count,
      .cur_recv_base, .cur_send_base, .cur_next_seq
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog
   initial begin
      cycles = 0;
      while (cycles < 200000) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // send one command word; start stays high across back-to-back words
   task automatic send_word(input swte_pkg::action_type a, input logic [31:0] pkt,
                            input logic [31:0] ack, input logic [15:0] h,
                            input logic [10:0] len);
      int gap;
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_word <= '{a, pkt, ack, h, len};
      do @(posedge clock); while (busy);
      word_count++;
   endtask

   // let the block go quiet before touching a register
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (busy || pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input swte_pkg::csr_index_type idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed traffic around the current windows, some noise
   task automatic random_word();
      int          pick;
      logic [31:0] pkt, ack;
      pick = $urandom_range(0, 99);
      pkt = cur_recv_base + 32'($urandom_range(0, 34)) - 32'd2;
      ack = cur_send_base - 32'd1 +
            32'($urandom_range(0, cur_next_seq - cur_send_base + 1));
      if (pick < 45)
         send_word(swte_pkg::ACT_RECV, ($urandom_range(0, 9) == 0) ? 32'd0 : pkt, ack,
                   16'($urandom), 11'($urandom_range(0, 2047)));
      else if (pick < 70)
         send_word(swte_pkg::ACT_SEND, $urandom, $urandom, 16'($urandom),
                   11'($urandom_range(0, 2047)));
      else if (pick < 92)
         send_word(swte_pkg::ACT_TICK, $urandom, $urandom, 16'($urandom), 11'($urandom));
      else if (pick < 97)
         send_word(swte_pkg::ACT_RECV, $urandom, $urandom, 16'($urandom), 11'($urandom));
      else
         send_word(swte_pkg::ACT_NONE, $urandom, $urandom, 16'($urandom), 11'($urandom));
   endtask

   initial begin
      logic [5:0]  wins [6] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd5, 6'd8};
      logic [31:0] tmos [6] = '{32'd1, 32'd3, 32'd0, 32'd2, 32'hFFFF_FFFF, 32'd4};
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_index = swte_pkg::CSR_WINDOW;
      csr_data = '0;
      req_word = '0;
      word_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, stopped timer, idle action
      send_word(swte_pkg::ACT_TICK, '0, '0, '0, '0);
      send_word(swte_pkg::ACT_NONE, '1, '1, '1, '1);
      send_word(swte_pkg::ACT_SEND, '0, '0, 16'hFFFF, 11'd2047);
      send_word(swte_pkg::ACT_SEND, '0, '0, 16'h0000, 11'd0);
      send_word(swte_pkg::ACT_SEND, '0, '0, 16'h5A5A, 11'd1024);
      // out of order, duplicate, then fill the gap
      send_word(swte_pkg::ACT_RECV, 32'd3, 32'd0, 16'h0003, 11'd3);
      send_word(swte_pkg::ACT_RECV, 32'd3, 32'd0, 16'hDEAD, 11'd9);
      send_word(swte_pkg::ACT_RECV, 32'd2, 32'd0, 16'h0002, 11'd2);
      send_word(swte_pkg::ACT_RECV, 32'd1, 32'd1, 16'h0001, 11'd1);
      // already delivered, far beyond window, pure ack, bogus acks
      send_word(swte_pkg::ACT_RECV, 32'd1, 32'hFFFF_FFFF, 16'h1111, 11'd5);
      send_word(swte_pkg::ACT_RECV, 32'd40, 32'd9, 16'h2222, 11'd6);
      send_word(swte_pkg::ACT_RECV, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 11'd2047);
      send_word(swte_pkg::ACT_RECV, 32'd0, 32'd2, 16'h3333, 11'd7);
      settle();
      // fast timeout, retransmit, full window with one slot
      write_reg(swte_pkg::CSR_TIMEOUT, 32'd1);
      write_reg(swte_pkg::CSR_WINDOW, 32'd1);
      send_word(swte_pkg::ACT_TICK, '0, '0, '0, '0);
      send_word(swte_pkg::ACT_TICK, '0, '0, '0, '0);
      send_word(swte_pkg::ACT_RECV, 32'd0, 32'd3, '0, '0);
      send_word(swte_pkg::ACT_SEND, '0, '0, 16'h4444, 11'd8);
      send_word(swte_pkg::ACT_SEND, '0, '0, 16'h5555, 11'd9);
      send_word(swte_pkg::ACT_TICK, '0, '0, '0, '0);
      send_word(swte_pkg::ACT_RECV, 32'd0, 32'd4, '0, '0);
      send_word(swte_pkg::ACT_TICK, '0, '0, '0, '0);

      // random phases under different settings
      foreach (wins[p]) begin
         settle();
         write_reg(swte_pkg::CSR_WINDOW, {26'd0, wins[p]});
         write_reg(swte_pkg::CSR_TIMEOUT, tmos[p]);
         repeat (22) random_word();
      end
      settle();
      repeat (10) @(posedge clock);

      $display("%0d command words sent across eight register settings, %0d result words checked",
               word_count, result_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d results never arrived", fail_count, pending_count);
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

/* files.f */
+incdir+rtl
rtl/swte_pkg.sv
rtl/swte_ring.sv
rtl/sliding_window_transport_endpoint_unit.sv
rtl/swte_checker.sv
test/swte_checker.sv
test/tb_top.sv
